/* hw/rtl/infix_to_postfix_converter_macros.svh */
// Assertion macros shared by the converter RTL.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define ITP_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A trigger that must be followed by a condition in the next cycle.
`define ITP_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

/* hw/rtl/itp_pkg.sv */
// Types, character constants and operator tables for the infix-to-postfix converter.
package itp_pkg;

    localparam int STACK_DEPTH_DEF = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [2:0] {
        OP_ADD  = 3'd0,
        OP_SUB  = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_MOD  = 3'd4,
        OP_POW  = 3'd5,
        OP_OPEN = 3'd6,
        OP_NONE = 3'd7
    } op_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_OP_POP,
        S_OP_SP,
        S_PUSH,
        S_CLOSE_POP,
        S_CLOSE_OP,
        S_END_SP,
        S_END_CHAR
    } state_t;

    // Operator code of a character; '(' maps to the open code, anything else to none.
    function automatic op_code_t char_op(input logic [7:0] c);
        op_code_t r;
        case (c)
            CH_PLUS:  r = OP_ADD;
            CH_MINUS: r = OP_SUB;
            CH_STAR:  r = OP_MUL;
            CH_SLASH: r = OP_DIV;
            CH_PCT:   r = OP_MOD;
            CH_CARET: r = OP_POW;
            CH_OPEN:  r = OP_OPEN;
            default:  r = OP_NONE;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] code_char(input op_code_t c);
        logic [7:0] r;
        case (c)
            OP_ADD:  r = CH_PLUS;
            OP_SUB:  r = CH_MINUS;
            OP_MUL:  r = CH_STAR;
            OP_DIV:  r = CH_SLASH;
            OP_MOD:  r = CH_PCT;
            OP_POW:  r = CH_CARET;
            OP_OPEN: r = CH_OPEN;
            default: r = CH_SPACE;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] code_prec(input op_code_t c);
        logic [1:0] r;
        case (c)
            OP_ADD, OP_SUB:         r = 2'd1;
            OP_MUL, OP_DIV, OP_MOD: r = 2'd2;
            OP_POW:                 r = 2'd3;
            default:                r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/infix_to_postfix_converter.sv */
// Infix-to-postfix converter: operator stack driven by a small sequencer.
//
//   channel   handshake                  payload
//   item      item_valid / item_stall    action, char_code
//   result    result_valid / result_stall out_char, last_of_run, push_dropped
//
// An item is decoded in the cycle after it is taken. A digit or '(' is done in decode;
// an operator adds a pop and a space state per pop, then a push; a ')' a pop and an
// operator state per printed pop; an end-of-expression a space and a char per entry.
// Reset clears the stack count and the sequencer; stack entries are not cleared.
// The sequencer waits while the output register holds a stalled transfer, and
// item_stall stays high until the item has produced all of its results.
module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       action,
    input  logic [7:0] char_code,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_char,
    output logic       last_of_run,
    output logic       push_dropped
);
    import itp_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             action_reg;
    logic [7:0]       char_reg;
    logic             drop_reg, drop_next;
    op_code_t         pop_reg, pop_next;
    logic [2:0]       stack_mem [STACK_DEPTH];

    logic             res_valid_reg;
    logic [7:0]       res_char_reg;
    logic             res_last_reg;
    logic             res_drop_reg;

    logic             emit;
    logic [7:0]       emit_char;
    logic             emit_last;
    logic             emit_drop;
    logic             push_en;

    logic             accept;
    logic             can_emit;
    logic [CNT_W-1:0] cnt_m1;
    op_code_t         top_code;
    op_code_t         code_in;
    logic             is_digit;
    logic             stack_full;
    logic             pop_cond;
    logic             close_quiet;
    logic             close_more;
    logic             pop_state;
    logic             emit_stalled;

    assign accept     = item_valid && !item_stall;
    assign can_emit   = !res_valid_reg || !result_stall;
    assign cnt_m1     = count_reg - CNT_W'(1);
    assign top_code   = op_code_t'(stack_mem[cnt_m1[IDX_W-1:0]]);
    assign code_in    = char_op(char_reg);
    assign stack_full = (count_reg == CNT_W'(STACK_DEPTH));
    assign pop_cond   = (count_reg != '0) && (code_prec(top_code) >= code_prec(code_in));
    // A pop in a close run is silent when it hits '(' or empties the stack.
    assign close_quiet = (top_code == OP_OPEN) || (count_reg == CNT_W'(1));
    assign close_more  = (count_reg >= CNT_W'(2)) && (top_code != OP_OPEN);
    assign pop_state    = state_reg inside {S_OP_POP, S_CLOSE_POP, S_END_SP};
    assign emit_stalled = emit && result_stall;

    always_comb
    begin
        is_digit = char_reg inside {[CH_ZERO:CH_NINE]};
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (action_reg)
                begin
                    if (can_emit)
                    begin
                        state_next = (count_reg == '0) ? S_IDLE : S_END_SP;
                    end
                end
                else if (is_digit)
                begin
                    if (can_emit)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (code_in == OP_OPEN)
                begin
                    if (!stack_full || can_emit)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (code_in != OP_NONE)
                begin
                    if (can_emit)
                    begin
                        state_next = pop_cond ? S_OP_POP : S_PUSH;
                    end
                end
                else if (char_reg == CH_CLOSE && count_reg != '0)
                begin
                    state_next = S_CLOSE_POP;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_OP_POP:
            begin
                if (can_emit)
                begin
                    state_next = S_OP_SP;
                end
            end
            S_OP_SP:
            begin
                if (can_emit)
                begin
                    state_next = pop_cond ? S_OP_POP : S_PUSH;
                end
            end
            S_PUSH:
            begin
                state_next = S_IDLE;
            end
            S_CLOSE_POP:
            begin
                if (close_quiet)
                begin
                    state_next = S_IDLE;
                end
                else if (can_emit)
                begin
                    state_next = S_CLOSE_OP;
                end
            end
            S_CLOSE_OP:
            begin
                if (can_emit)
                begin
                    state_next = (count_reg != '0) ? S_CLOSE_POP : S_IDLE;
                end
            end
            S_END_SP:
            begin
                if (can_emit)
                begin
                    state_next = S_END_CHAR;
                end
            end
            S_END_CHAR:
            begin
                if (can_emit)
                begin
                    state_next = (count_reg == '0) ? S_IDLE : S_END_SP;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output and datapath control.
    always_comb
    begin
        emit       = 1'b0;
        emit_char  = CH_SPACE;
        emit_last  = 1'b0;
        emit_drop  = drop_reg;
        push_en    = 1'b0;
        count_next = count_reg;
        drop_next  = drop_reg;
        pop_next   = pop_reg;
        item_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    drop_next = 1'b0;
                end
            end
            S_DECODE:
            begin
                if (action_reg)
                begin
                    emit      = can_emit;
                    emit_last = (count_reg == '0);
                end
                else if (is_digit)
                begin
                    emit      = can_emit;
                    emit_char = char_reg;
                    emit_last = 1'b1;
                end
                else if (code_in == OP_OPEN)
                begin
                    if (stack_full)
                    begin
                        emit      = can_emit;
                        emit_char = CH_NUL;
                        emit_last = 1'b1;
                        emit_drop = 1'b1;
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        push_en    = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                else if (code_in != OP_NONE)
                begin
                    // The push can only fail when nothing is popped first.
                    emit      = can_emit;
                    emit_last = !pop_cond;
                    emit_drop = stack_full && !pop_cond;
                    drop_next = stack_full && !pop_cond;
                end
            end
            S_OP_POP:
            begin
                emit      = can_emit;
                emit_char = code_char(top_code);
                if (can_emit)
                begin
                    count_next = cnt_m1;
                end
            end
            S_OP_SP:
            begin
                emit      = can_emit;
                emit_last = !pop_cond;
            end
            S_PUSH:
            begin
                if (!drop_reg)
                begin
                    push_en    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            S_CLOSE_POP:
            begin
                if (close_quiet)
                begin
                    count_next = cnt_m1;
                end
                else if (can_emit)
                begin
                    emit       = 1'b1;
                    count_next = cnt_m1;
                    pop_next   = top_code;
                end
            end
            S_CLOSE_OP:
            begin
                emit      = can_emit;
                emit_char = code_char(pop_reg);
                emit_last = !close_more;
            end
            S_END_SP:
            begin
                emit = can_emit;
                if (can_emit)
                begin
                    count_next = cnt_m1;
                    pop_next   = top_code;
                end
            end
            S_END_CHAR:
            begin
                emit      = can_emit;
                emit_char = code_char(pop_reg);
                emit_last = (count_reg == '0);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
            drop_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            drop_reg  <= drop_next;
            if (emit)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pop_reg <= pop_next;
        if (accept)
        begin
            action_reg <= action;
            char_reg   <= char_code;
        end
        if (emit)
        begin
            res_char_reg <= emit_char;
            res_last_reg <= emit_last;
            res_drop_reg <= emit_drop;
        end
        if (push_en)
        begin
            stack_mem[count_reg[IDX_W-1:0]] <= code_in;
        end
    end

    assign result_valid = res_valid_reg;
    assign out_char     = res_char_reg;
    assign last_of_run  = res_last_reg;
    assign push_dropped = res_drop_reg;

`include "infix_to_postfix_converter_macros.svh"

    `ITP_ASSERT_ALWAYS(a_count_range, count_reg <= CNT_W'(STACK_DEPTH), "stack count overflow")
    `ITP_ASSERT_ALWAYS(a_pop_nonempty, !pop_state || count_reg != '0, "pop from empty stack")
    `ITP_ASSERT_NEXT(a_accept_decode, accept, state_reg == S_DECODE, "accepted item not decoded")
    `ITP_ASSERT_NEXT(a_emit_holds, emit_stalled, out_char == $past(emit_char), "result lost")

endmodule

/* tb/itp_checker.sv */
// Result checker for the infix-to-postfix converter: predicts each transfer's output and compares.
module itp_checker #(
    parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  logic       item_stall,
    input  logic       action,
    input  logic [7:0] char_code,
    input  logic       result_valid,
    input  logic       result_stall,
    input  logic [7:0] out_char,
    input  logic       last_of_run,
    input  logic       push_dropped,
    output int         errors,
    output int         pending
);
    import itp_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       is_last;
        logic       dropped;
    } postfix_char_t;

    postfix_char_t postfix_q[$];
    postfix_char_t want;
    op_code_t      op_stack[STACK_DEPTH];
    int            stack_fill;

    function automatic logic [1:0] precedence(input op_code_t op);
        case (op)
            OP_ADD, OP_SUB:         return 2'd1;
            OP_MUL, OP_DIV, OP_MOD: return 2'd2;
            OP_POW:                 return 2'd3;
            default:                return 2'd0;
        endcase
    endfunction

    function automatic logic [7:0] op_to_char(input op_code_t op);
        case (op)
            OP_ADD:  return CH_PLUS;
            OP_SUB:  return CH_MINUS;
            OP_MUL:  return CH_STAR;
            OP_DIV:  return CH_SLASH;
            OP_MOD:  return CH_PCT;
            OP_POW:  return CH_CARET;
            OP_OPEN: return CH_OPEN;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic op_code_t char_to_op(input logic [7:0] c);
        case (c)
            CH_PLUS:  return OP_ADD;
            CH_MINUS: return OP_SUB;
            CH_STAR:  return OP_MUL;
            CH_SLASH: return OP_DIV;
            CH_PCT:   return OP_MOD;
            CH_CARET: return OP_POW;
            default:  return OP_NONE;
        endcase
    endfunction

    // Runs one accepted item through the operator stack and queues the characters it yields.
    function automatic void convert_char(input logic act, input logic [7:0] c);
        logic [7:0] outs[$];
        logic       drop;
        op_code_t   op;
        op_code_t   top;
        drop = 1'b0;
        op = char_to_op(c);
        if (act) begin
            outs.push_back(CH_SPACE);
            while (stack_fill > 0) begin
                stack_fill--;
                outs.push_back(CH_SPACE);
                outs.push_back(op_to_char(op_stack[stack_fill]));
            end
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            outs.push_back(c);
        end else if (c == CH_OPEN) begin
            if (stack_fill < STACK_DEPTH) begin
                op_stack[stack_fill] = OP_OPEN;
                stack_fill++;
            end else begin
                // A lost open bracket still shows up as a single marker character.
                drop = 1'b1;
                outs.push_back(CH_NUL);
            end
        end else if (c == CH_CLOSE) begin
            while (stack_fill > 0) begin
                stack_fill--;
                top = op_stack[stack_fill];
                // The operator that empties the stack is discarded silently.
                if (top == OP_OPEN || stack_fill == 0)
                    break;
                outs.push_back(CH_SPACE);
                outs.push_back(op_to_char(top));
            end
        end else if (op != OP_NONE) begin
            outs.push_back(CH_SPACE);
            while (stack_fill > 0 && precedence(op_stack[stack_fill - 1]) >= precedence(op)) begin
                stack_fill--;
                outs.push_back(op_to_char(op_stack[stack_fill]));
                outs.push_back(CH_SPACE);
            end
            if (stack_fill < STACK_DEPTH) begin
                op_stack[stack_fill] = op;
                stack_fill++;
            end else begin
                drop = 1'b1;
            end
        end
        foreach (outs[i])
            postfix_q.push_back('{ch: outs[i], is_last: (i == outs.size() - 1), dropped: drop});
    endfunction

    initial
    begin
        errors = 0;
        pending = 0;
        stack_fill = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n) begin
            stack_fill = 0;
        end else begin
            if (item_valid && !item_stall)
                convert_char(action, char_code);
            if (result_valid && !result_stall) begin
                if (postfix_q.size() == 0) begin
                    errors++;
                    if (errors <= 100)
                        $display("%0t: unexpected transfer: expected none, got char %h last %b dropped %b",
                                 $time, out_char, last_of_run, push_dropped);
                end else begin
                    want = postfix_q.pop_front();
                    if (want.ch !== out_char || want.is_last !== last_of_run ||
                        want.dropped !== push_dropped) begin
                        errors++;
                        if (errors <= 100)
                            $display("%0t: mismatch: expected char %h last %b dropped %b, got char %h last %b dropped %b",
                                     $time, want.ch, want.is_last, want.dropped,
                                     out_char, last_of_run, push_dropped);
                    end
                end
            end
            pending = postfix_q.size();
        end
    end

endmodule

/* tb/infix_to_postfix_converter_tb.sv */
// Testbench top for the infix-to-postfix converter: clock, reset, stimulus and verdict.
module infix_to_postfix_converter_tb;
    import itp_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       item_valid;
    logic       item_stall;
    logic       action;
    logic [7:0] char_code;
    logic       result_valid;
    logic       result_stall;
    logic [7:0] out_char;
    logic       last_of_run;
    logic       push_dropped;

    int errors;
    int pending;
    int items_sent;
    int tx_idle_pct;
    int rx_idle_pct;
    bit long_hold_req;
    bit long_hold_done;

    infix_to_postfix_converter u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .char_code    (char_code),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_char     (out_char),
        .last_of_run  (last_of_run),
        .push_dropped (push_dropped)
    );

    itp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .action       (action),
        .char_code    (char_code),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_char     (out_char),
        .last_of_run  (last_of_run),
        .push_dropped (push_dropped),
        .errors       (errors),
        .pending      (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: random stall, plus one long hold so the converter backs up into the input.
    initial
    begin
        result_stall <= 1'b0;
        long_hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold_req && !long_hold_done)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            result_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_item(input logic act, input logic [7:0] c);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        action     <= act;
        char_code  <= c;
        do
            @(posedge clk);
        while (item_stall);
        items_sent++;
    endtask

    // Mostly well-formed expressions with random content; some noise bytes and deep nesting.
    task automatic send_expression();
        int         depth;
        int         len;
        bit         want_operand;
        logic [7:0] c;
        depth = 0;
        want_operand = 1'b1;
        len = $urandom_range(1, 14);
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(12, 18))
            begin
                send_item(1'b0, CH_OPEN);
                depth++;
            end
        end
        for (int k = 0; k < len; k++)
        begin
            if ($urandom_range(19) == 0)
            begin
                c = 8'($urandom_range(255));
            end
            else if (want_operand)
            begin
                if ($urandom_range(3) == 0)
                begin
                    c = CH_OPEN;
                    depth++;
                end
                else
                begin
                    c = CH_ZERO + 8'($urandom_range(9));
                    want_operand = 1'b0;
                end
            end
            else if (depth > 0 && $urandom_range(3) == 0)
            begin
                c = CH_CLOSE;
                depth--;
            end
            else
            begin
                case ($urandom_range(5))
                    0:       c = CH_PLUS;
                    1:       c = CH_MINUS;
                    2:       c = CH_STAR;
                    3:       c = CH_SLASH;
                    4:       c = CH_PCT;
                    default: c = CH_CARET;
                endcase
                want_operand = 1'b1;
            end
            send_item(1'b0, c);
        end
        if ($urandom_range(1) == 0)
        begin
            while (depth > 0)
            begin
                send_item(1'b0, CH_CLOSE);
                depth--;
            end
        end
        if ($urandom_range(7) != 0)
            send_item(1'b1, 8'($urandom_range(255)));
    endtask

    initial
    begin
        int wait_cycles;
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        action      <= 1'b0;
        char_code   <= CH_NUL;
        items_sent = 0;
        tx_idle_pct = 37;
        rx_idle_pct = 79;
        long_hold_req = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: digit extremes, every operator, left-associative power, brackets.
        send_item(1'b0, CH_ZERO);
        send_item(1'b0, CH_NINE);
        send_item(1'b0, CH_OPEN);
        send_item(1'b0, "1");
        send_item(1'b0, CH_PLUS);
        send_item(1'b0, "2");
        send_item(1'b0, CH_CLOSE);
        send_item(1'b0, CH_STAR);
        send_item(1'b0, "3");
        send_item(1'b0, CH_CARET);
        send_item(1'b0, "2");
        send_item(1'b0, CH_CARET);
        send_item(1'b0, "4");
        send_item(1'b0, CH_PCT);
        send_item(1'b0, "5");
        send_item(1'b0, CH_SLASH);
        send_item(1'b0, "6");
        send_item(1'b0, CH_MINUS);
        send_item(1'b0, "7");
        send_item(1'b1, CH_PLUS);
        // Close on an empty stack, then a close that empties the stack on an operator.
        send_item(1'b0, CH_CLOSE);
        send_item(1'b0, CH_PLUS);
        send_item(1'b0, CH_CLOSE);
        send_item(1'b0, "A");
        send_item(1'b0, 8'hFF);

        while (items_sent < 150)
            send_expression();
        tx_idle_pct = 79;
        rx_idle_pct = 37;
        while (items_sent < 290)
            send_expression();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_hold_req = 1'b1;
        while (items_sent < 430)
            send_expression();
        item_valid <= 1'b0;
        @(posedge clk);

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/itp_pkg.sv
hw/rtl/infix_to_postfix_converter.sv
tb/itp_checker.sv
tb/infix_to_postfix_converter_tb.sv
